// ===== hdl/kzrt_pkg.sv =====
package kzrt_pkg;

   localparam int FIELD_W        = 11;
   localparam int VALUE_W        = 32;
   localparam int RESULT_W       = 12;
   localparam int LEAF_COUNT_DEF = 1024;

   localparam logic signed [RESULT_W-1:0] RESULT_NONE = '1;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_U_CHECK,
      ST_U_UP,
      ST_Q_PRE,
      ST_Q_ROOT,
      ST_Q_TOP,
      ST_Q_DESC,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_UPD_LEAF,
      OP_UPD_CHECK,
      OP_UPD_UP,
      OP_PRE,
      OP_ROOT,
      OP_TOP,
      OP_DESC,
      OP_MISS,
      OP_SEND
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_query;
      logic upd_in_range;
      logic rank_zero;
      logic pre_empty;
      logic leaf_same;
      logic at_root;
      logic pre_last;
      logic too_few;
      logic desc_last;
      logic rsp_free;
   } sts_type;

endpackage

// ===== hdl/kzrt_ram.sv =====
module kzrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/kzrt_ctrl.sv =====
module kzrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kzrt_pkg::sts_type sts,
   output kzrt_pkg::cmd_type cmd
);

   kzrt_pkg::state_type state_ff;
   kzrt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kzrt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kzrt_pkg::ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = kzrt_pkg::ST_IDLE;
            end
         end
         kzrt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kzrt_pkg::ST_DISPATCH;
            end
         end
         kzrt_pkg::ST_DISPATCH: begin
            priority if (!sts.is_query && sts.upd_in_range) begin
               state_in = kzrt_pkg::ST_U_CHECK;
            end else if (!sts.is_query) begin
               state_in = kzrt_pkg::ST_IDLE;
            end else if (sts.rank_zero) begin
               state_in = kzrt_pkg::ST_DONE;
            end else if (sts.pre_empty) begin
               state_in = kzrt_pkg::ST_Q_ROOT;
            end else begin
               state_in = kzrt_pkg::ST_Q_PRE;
            end
         end
         kzrt_pkg::ST_U_CHECK: begin
            state_in = sts.leaf_same ? kzrt_pkg::ST_IDLE : kzrt_pkg::ST_U_UP;
         end
         kzrt_pkg::ST_U_UP: begin
            if (sts.at_root) begin
               state_in = kzrt_pkg::ST_IDLE;
            end
         end
         kzrt_pkg::ST_Q_PRE: begin
            if (sts.pre_last) begin
               state_in = kzrt_pkg::ST_Q_ROOT;
            end
         end
         kzrt_pkg::ST_Q_ROOT: begin
            state_in = kzrt_pkg::ST_Q_TOP;
         end
         kzrt_pkg::ST_Q_TOP: begin
            state_in = sts.too_few ? kzrt_pkg::ST_DONE : kzrt_pkg::ST_Q_DESC;
         end
         kzrt_pkg::ST_Q_DESC: begin
            if (sts.desc_last) begin
               state_in = kzrt_pkg::ST_DONE;
            end
         end
         kzrt_pkg::ST_DONE: begin
            if (sts.rsp_free) begin
               state_in = kzrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kzrt_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = kzrt_pkg::OP_NONE;
      unique case (state_ff)
         kzrt_pkg::ST_CLEAR: begin
            cmd.op = kzrt_pkg::OP_CLEAR;
         end
         kzrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = kzrt_pkg::OP_LOAD;
            end
         end
         kzrt_pkg::ST_DISPATCH: begin
            priority if (!sts.is_query && sts.upd_in_range) begin
               cmd.op = kzrt_pkg::OP_UPD_LEAF;
            end else if (sts.is_query && sts.rank_zero) begin
               cmd.op = kzrt_pkg::OP_MISS;
            end else begin
               cmd.op = kzrt_pkg::OP_NONE;
            end
         end
         kzrt_pkg::ST_U_CHECK: begin
            cmd.op = kzrt_pkg::OP_UPD_CHECK;
         end
         kzrt_pkg::ST_U_UP: begin
            cmd.op = kzrt_pkg::OP_UPD_UP;
         end
         kzrt_pkg::ST_Q_PRE: begin
            cmd.op = kzrt_pkg::OP_PRE;
         end
         kzrt_pkg::ST_Q_ROOT: begin
            cmd.op = kzrt_pkg::OP_ROOT;
         end
         kzrt_pkg::ST_Q_TOP: begin
            cmd.op = kzrt_pkg::OP_TOP;
         end
         kzrt_pkg::ST_Q_DESC: begin
            cmd.op = kzrt_pkg::OP_DESC;
         end
         kzrt_pkg::ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.op = kzrt_pkg::OP_SEND;
            end
         end
         default: begin
            cmd.op = kzrt_pkg::OP_NONE;
         end
      endcase
   end

endmodule

// ===== hdl/kzrt_dp.sv =====
module kzrt_dp #(
   parameter int LEAF_COUNT = kzrt_pkg::LEAF_COUNT_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  kzrt_pkg::cmd_type                        cmd,
   output kzrt_pkg::sts_type                        sts,
   input  logic                                     req_type,
   input  logic [kzrt_pkg::FIELD_W-1:0]             req_elem_pos,
   input  logic signed [kzrt_pkg::VALUE_W-1:0]      req_new_value,
   input  logic [kzrt_pkg::FIELD_W-1:0]             req_range_start,
   input  logic [kzrt_pkg::FIELD_W-1:0]             req_range_end,
   input  logic [kzrt_pkg::FIELD_W-1:0]             req_zero_rank,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [kzrt_pkg::RESULT_W-1:0]     rsp_zero_position
);

   localparam int LOG   = $clog2(LEAF_COUNT);
   localparam int AW    = LOG + 1;
   localparam int CW    = LOG + 1;
   localparam int XW    = ((AW > kzrt_pkg::FIELD_W) ? AW : kzrt_pkg::FIELD_W) + 1;
   localparam int DEPTH = 2 ** AW;

   // node count memory, heap order, root at 1, leaves in the upper half
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [CW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [CW-1:0] ram_rdata;

   kzrt_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic [AW-1:0]                          node_ff, node_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   first_ff, first_in;
   logic                                   use_ff, use_in;
   logic [XW-1:0]                          acc_ff, acc_in;
   logic [XW-1:0]                          target_ff, target_in;
   logic                                   type_ff, type_in;
   logic                                   flag_ff, flag_in;
   logic                                   pos_ok_ff, pos_ok_in;
   logic                                   pre_empty_ff, pre_empty_in;
   logic [kzrt_pkg::FIELD_W-1:0]           end_ff, end_in;
   logic [kzrt_pkg::FIELD_W-1:0]           rank_ff, rank_in;
   logic signed [kzrt_pkg::RESULT_W-1:0]   result_ff, result_in;
   logic signed [kzrt_pkg::RESULT_W-1:0]   rsp_pos_ff, rsp_pos_in;

   logic [XW-1:0] pos_x, start_x, lc_x, x_raw, x_sat, pos_m1, x_m1;
   logic [AW-1:0] leaf_upd, leaf_qry, node_up, child;
   logic [XW-1:0] rdata_x, acc_add, target_sum, tgt_next, pos_found;
   logic [CW-1:0] count_step;
   logic          go_left, in_end;

   // request decode
   always_comb begin
      pos_x    = XW'(req_elem_pos);
      start_x  = XW'(req_range_start);
      lc_x     = XW'(LEAF_COUNT);
      x_raw    = (start_x == '0) ? '0 : start_x - XW'(1);
      x_sat    = (x_raw > lc_x) ? lc_x : x_raw;
      pos_m1   = pos_x - XW'(1);
      x_m1     = x_sat - XW'(1);
      leaf_upd = {1'b1, pos_m1[LOG-1:0]};
      leaf_qry = {1'b1, x_m1[LOG-1:0]};
   end

   // tree arithmetic
   always_comb begin
      rdata_x    = XW'(ram_rdata);
      node_up    = {1'b0, node_ff[AW-1:1]};
      acc_add    = acc_ff + (use_ff ? rdata_x : '0);
      target_sum = acc_ff + XW'(rank_ff);
      go_left    = target_ff <= rdata_x;
      child      = {node_ff[AW-2:0], ~go_left};
      tgt_next   = go_left ? target_ff : target_ff - rdata_x;
      pos_found  = XW'(child[LOG-1:0]) + XW'(1);
      in_end     = pos_found <= XW'(end_ff);
      count_step = flag_ff ? ram_rdata + CW'(1) : ram_rdata - CW'(1);
   end

   always_comb begin
      sts.clear_done   = &node_ff;
      sts.is_query     = type_ff;
      sts.upd_in_range = pos_ok_ff;
      sts.rank_zero    = (rank_ff == '0);
      sts.pre_empty    = pre_empty_ff;
      sts.leaf_same    = (ram_rdata[0] == flag_ff);
      sts.at_root      = (node_ff == AW'(1));
      sts.pre_last     = !first_ff && (node_up == AW'(1));
      sts.too_few      = target_sum > rdata_x;
      sts.desc_last    = child[AW-1];
      sts.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ram_we       = 1'b0;
      ram_waddr    = node_ff;
      ram_wdata    = '0;
      ram_raddr    = '0;
      node_in      = node_ff;
      first_in     = first_ff;
      use_in       = use_ff;
      acc_in       = acc_ff;
      target_in    = target_ff;
      type_in      = type_ff;
      flag_in      = flag_ff;
      pos_ok_in    = pos_ok_ff;
      pre_empty_in = pre_empty_ff;
      end_in       = end_ff;
      rank_in      = rank_ff;
      result_in    = result_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (cmd.op)
         kzrt_pkg::OP_NONE: begin
         end
         kzrt_pkg::OP_CLEAR: begin
            ram_we  = 1'b1;
            node_in = node_ff + AW'(1);
         end
         kzrt_pkg::OP_LOAD: begin
            type_in      = (req_type == kzrt_pkg::REQ_QUERY);
            flag_in      = (req_new_value == '0);
            pos_ok_in    = (pos_x != '0) && (pos_x <= lc_x);
            pre_empty_in = (x_sat == '0);
            end_in       = req_range_end;
            rank_in      = req_zero_rank;
            node_in      = (req_type == kzrt_pkg::REQ_QUERY) ? leaf_qry : leaf_upd;
            acc_in       = '0;
            use_in       = 1'b0;
            first_in     = 1'b1;
         end
         kzrt_pkg::OP_UPD_LEAF: begin
            ram_raddr = node_ff;
         end
         kzrt_pkg::OP_UPD_CHECK: begin
            if (ram_rdata[0] != flag_ff) begin
               ram_we    = 1'b1;
               ram_wdata = CW'(flag_ff);
               ram_raddr = node_up;
               node_in   = node_up;
            end
         end
         kzrt_pkg::OP_UPD_UP: begin
            ram_we    = 1'b1;
            ram_wdata = count_step;
            ram_raddr = node_up;
            node_in   = node_up;
         end
         kzrt_pkg::OP_PRE: begin
            // prefix walk: the leaf, then every left sibling on the way up
            acc_in = acc_add;
            if (first_ff) begin
               ram_raddr = node_ff;
               use_in    = 1'b1;
               first_in  = 1'b0;
            end else begin
               ram_raddr = node_ff - AW'(1);
               use_in    = node_ff[0];
               node_in   = node_up;
            end
         end
         kzrt_pkg::OP_ROOT: begin
            acc_in    = acc_add;
            ram_raddr = AW'(1);
            use_in    = 1'b0;
         end
         kzrt_pkg::OP_TOP: begin
            if (target_sum > rdata_x) begin
               result_in = kzrt_pkg::RESULT_NONE;
            end else begin
               target_in = target_sum;
               node_in   = AW'(1);
               ram_raddr = AW'(2);
            end
         end
         kzrt_pkg::OP_DESC: begin
            node_in   = child;
            target_in = tgt_next;
            ram_raddr = {child[AW-2:0], 1'b0};
            if (child[AW-1]) begin
               result_in = in_end ? $signed(pos_found[kzrt_pkg::RESULT_W-1:0])
                                  : kzrt_pkg::RESULT_NONE;
            end
         end
         kzrt_pkg::OP_MISS: begin
            result_in = kzrt_pkg::RESULT_NONE;
         end
         kzrt_pkg::OP_SEND: begin
            rsp_pos_in   = result_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      use_ff       <= use_in;
      acc_ff       <= acc_in;
      target_ff    <= target_in;
      type_ff      <= type_in;
      flag_ff      <= flag_in;
      pos_ok_ff    <= pos_ok_in;
      pre_empty_ff <= pre_empty_in;
      end_ff       <= end_in;
      rank_ff      <= rank_in;
      result_ff    <= result_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_zero_position = rsp_pos_ff;

   a_send_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == kzrt_pkg::OP_SEND |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");

   a_no_count_underflow: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == kzrt_pkg::OP_UPD_UP && !flag_ff) |-> ram_rdata != '0)
      else $error("node zero count underflow");

   a_no_count_overflow: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == kzrt_pkg::OP_UPD_UP && flag_ff) |-> ram_rdata != '1)
      else $error("node zero count overflow");

   a_desc_target_live: assert property (@(posedge clock) disable iff (reset)
      cmd.op == kzrt_pkg::OP_DESC |-> target_ff != '0)
      else $error("descent with zero target rank");

endmodule

// ===== hdl/kth_zero_range_tree.sv =====
// Finds the k-th zero inside a range of an array of LEAF_COUNT elements
// (positions from 1) using a tree of zero counts held in one memory of
// 2*2^clog2(LEAF_COUNT) entries with one read and one write port. After reset
// the block sweeps that memory to zero before it takes its first beat. An
// update gives no result, and it stops early when the element's zero flag
// does not change or when its position is out of range. A query makes a
// walk up from the leaf before the range start to count earlier zeros, a
// root read, then a walk down to the wanted leaf, one node count memory
// read per tree level. A query with rank zero, or with too few zeros,
// returns -1 earlier. The result sits in an output register, so the next
// beat is taken while it waits.
module kth_zero_range_tree #(
   parameter int LEAF_COUNT = kzrt_pkg::LEAF_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [kzrt_pkg::FIELD_W-1:0]         req_elem_pos,
   input  logic signed [kzrt_pkg::VALUE_W-1:0]  req_new_value,
   input  logic [kzrt_pkg::FIELD_W-1:0]         req_range_start,
   input  logic [kzrt_pkg::FIELD_W-1:0]         req_range_end,
   input  logic [kzrt_pkg::FIELD_W-1:0]         req_zero_rank,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [kzrt_pkg::RESULT_W-1:0] rsp_zero_position
);

   kzrt_pkg::cmd_type cmd;
   kzrt_pkg::sts_type sts;

   kzrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kzrt_dp #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_elem_pos      (req_elem_pos),
      .req_new_value     (req_new_value),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .req_zero_rank     (req_zero_rank),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_zero_position (rsp_zero_position)
   );

endmodule

// ===== sim/kth_zero_range_tree_tb.sv =====
`timescale 1ns / 100ps

module kth_zero_range_tree_tb;

   localparam int LEAVES       = kzrt_pkg::LEAF_COUNT_DEF;
   localparam int FIELD_MAX    = (1 << kzrt_pkg::FIELD_W) - 1;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      logic                                kind;
      logic [kzrt_pkg::FIELD_W-1:0]        pos;
      logic signed [kzrt_pkg::VALUE_W-1:0] value;
      logic [kzrt_pkg::FIELD_W-1:0]        first;
      logic [kzrt_pkg::FIELD_W-1:0]        last;
      logic [kzrt_pkg::FIELD_W-1:0]        rank;
   } tree_req_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic                                 req_type = kzrt_pkg::REQ_UPDATE;
   logic [kzrt_pkg::FIELD_W-1:0]         req_elem_pos = '0;
   logic signed [kzrt_pkg::VALUE_W-1:0]  req_new_value = '0;
   logic [kzrt_pkg::FIELD_W-1:0]         req_range_start = '0;
   logic [kzrt_pkg::FIELD_W-1:0]         req_range_end = '0;
   logic [kzrt_pkg::FIELD_W-1:0]         req_zero_rank = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [kzrt_pkg::RESULT_W-1:0] rsp_zero_position;

   tree_req_type                         beat_queue[$];
   logic signed [kzrt_pkg::RESULT_W-1:0] position_queue[$];
   logic signed [kzrt_pkg::RESULT_W-1:0] expected_position;
   tree_req_type                         next_beat;
   bit                                   zero_flag[1:LEAVES];
   int                                   send_idle_pct = 0;
   int                                   stall_pct = 0;
   int                                   error_count = 0;
   int                                   idle_cycles = 0;

   kth_zero_range_tree dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_elem_pos      (req_elem_pos),
      .req_new_value     (req_new_value),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .req_zero_rank     (req_zero_rank),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_zero_position (rsp_zero_position)
   );

   always #4 clock = ~clock;

   // zeros at positions 1..last, last saturated to the tree size
   function automatic int zeros_through(input int last);
      int n;
      n = 0;
      if (last > LEAVES) last = LEAVES;
      for (int i = 1; i <= last; i++) n += zero_flag[i];
      return n;
   endfunction

   function automatic logic signed [kzrt_pkg::RESULT_W-1:0] kth_zero_lookup(
      input logic [kzrt_pkg::FIELD_W-1:0] first,
      input logic [kzrt_pkg::FIELD_W-1:0] last,
      input logic [kzrt_pkg::FIELD_W-1:0] rank
   );
      int target;
      int seen;
      logic signed [kzrt_pkg::RESULT_W-1:0] found;
      found = kzrt_pkg::RESULT_NONE;
      target = ((first == 0) ? 0 : zeros_through(int'(first) - 1)) + int'(rank);
      if (rank != 0 && zeros_through(int'(last)) >= target) begin
         seen = 0;
         for (int i = 1; i <= LEAVES; i++) begin
            seen += zero_flag[i];
            if (zero_flag[i] && seen == target) found = kzrt_pkg::RESULT_W'(i);
         end
      end
      return found;
   endfunction

   function automatic tree_req_type random_beat();
      tree_req_type beat;
      beat.kind  = 1'($urandom_range(1));
      beat.pos   = kzrt_pkg::FIELD_W'($urandom_range(FIELD_MAX));
      beat.value = $urandom;
      beat.first = kzrt_pkg::FIELD_W'($urandom_range(FIELD_MAX));
      beat.last  = kzrt_pkg::FIELD_W'($urandom_range(FIELD_MAX));
      beat.rank  = kzrt_pkg::FIELD_W'($urandom_range(FIELD_MAX));
      return beat;
   endfunction

   function automatic tree_req_type make_update(input int pos,
                                                input logic [kzrt_pkg::VALUE_W-1:0] value);
      tree_req_type beat;
      beat = random_beat();
      beat.kind  = kzrt_pkg::REQ_UPDATE;
      beat.pos   = kzrt_pkg::FIELD_W'(pos);
      beat.value = value;
      return beat;
   endfunction

   function automatic tree_req_type make_query(input int first, input int last, input int rank);
      tree_req_type beat;
      beat = random_beat();
      beat.kind  = kzrt_pkg::REQ_QUERY;
      beat.first = kzrt_pkg::FIELD_W'(first);
      beat.last  = kzrt_pkg::FIELD_W'(last);
      beat.rank  = kzrt_pkg::FIELD_W'(rank);
      return beat;
   endfunction

   task automatic wait_all_results();
      @(negedge clock);
      while (beat_queue.size() != 0 || req_valid || position_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int stall, input int count);
      int pick;
      int first;
      int last;
      tree_req_type beat;
      send_idle_pct = send_pct;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         beat = random_beat();
         if (pick < 45) begin
            beat.kind = kzrt_pkg::REQ_UPDATE;
            beat.pos = kzrt_pkg::FIELD_W'(($urandom_range(3) == 0) ? $urandom_range(1, LEAVES)
                                                                   : $urandom_range(1, 256));
            if ($urandom_range(1) == 1) beat.value = '0;
         end else if (pick < 92) begin
            first = ($urandom_range(1) == 1) ? $urandom_range(1, 256) : $urandom_range(1, LEAVES);
            if ($urandom_range(1) == 1) begin
               last = first + $urandom_range(0, 31);
               if (last > LEAVES) last = LEAVES;
            end else begin
               last = $urandom_range(first, LEAVES);
            end
            beat.kind  = kzrt_pkg::REQ_QUERY;
            beat.first = kzrt_pkg::FIELD_W'(first);
            beat.last  = kzrt_pkg::FIELD_W'(last);
            beat.rank  = kzrt_pkg::FIELD_W'($urandom_range(0, (last - first + 1) / 2 + 2));
         end
         beat_queue.push_back(beat);
      end
      // sender holds off until the block has drained
      wait_all_results();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_type == kzrt_pkg::REQ_QUERY) begin
               position_queue.push_back(kth_zero_lookup(req_range_start, req_range_end,
                                                        req_zero_rank));
            end else if (req_elem_pos >= 1 && req_elem_pos <= LEAVES) begin
               zero_flag[req_elem_pos] = (req_new_value == 0);
            end
         end
         if (!req_valid || req_ready) begin
            if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = beat_queue.pop_front();
               req_type        <= next_beat.kind;
               req_elem_pos    <= next_beat.pos;
               req_new_value   <= next_beat.value;
               req_range_start <= next_beat.first;
               req_range_end   <= next_beat.last;
               req_zero_rank   <= next_beat.rank;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (position_queue.size() == 0) begin
               $display("%0t: unexpected zero_position beat, expected none, actual %0d",
                        $time, rsp_zero_position);
               error_count++;
            end else begin
               expected_position = position_queue.pop_front();
               if (rsp_zero_position !== expected_position) begin
                  $display("%0t: zero_position mismatch, expected %0d, actual %0d",
                           $time, expected_position, rsp_zero_position);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty tree, edges, saturation, rank zero, empty range
      beat_queue.push_back(make_query(1, LEAVES, 1));
      beat_queue.push_back(make_update(1, 0));
      beat_queue.push_back(make_update(LEAVES, 0));
      beat_queue.push_back(make_update(512, 0));
      beat_queue.push_back(make_update(0, 0));
      beat_queue.push_back(make_update(LEAVES + 1, 0));
      beat_queue.push_back(make_update(FIELD_MAX, 0));
      beat_queue.push_back(make_query(1, LEAVES, 0));
      beat_queue.push_back(make_query(1, LEAVES, 1));
      beat_queue.push_back(make_query(1, LEAVES, 3));
      beat_queue.push_back(make_query(2, LEAVES, 1));
      beat_queue.push_back(make_query(0, FIELD_MAX, 2));
      beat_queue.push_back(make_query(600, 500, 1));
      beat_queue.push_back(make_query(1, LEAVES, FIELD_MAX));
      beat_queue.push_back(make_query(1, LEAVES, 4));
      beat_queue.push_back(make_query(FIELD_MAX, FIELD_MAX, 1));
      beat_queue.push_back(make_update(1, 32'h8000_0000));
      beat_queue.push_back(make_update(LEAVES, 32'h7FFF_FFFF));
      beat_queue.push_back(make_query(1, LEAVES, 1));
      beat_queue.push_back(make_update(512, 32'hFFFF_FFFF));
      beat_queue.push_back(make_query(1, LEAVES, 1));
      beat_queue.push_back(make_update(700, 0));
      beat_queue.push_back(make_query(700, 700, 1));
      beat_queue.push_back(make_query(701, LEAVES, 1));
      wait_all_results();

      run_phase(0, 0, 390);
      run_phase(66, 0, 385);
      run_phase(0, 66, 385);
      run_phase(7, 7, 390);

      wait_all_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && position_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kzrt_pkg.sv
hdl/kzrt_ram.sv
hdl/kzrt_ctrl.sv
hdl/kzrt_dp.sv
hdl/kth_zero_range_tree.sv
sim/kth_zero_range_tree_tb.sv
